### rtl/core/vtt_pkg.sv
// shared types, constants, tables and hash helpers of the voxel truchet tile generator
package vtt_pkg;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CAM_POS_X   = 3'd0,
    REG_CAM_POS_Y   = 3'd1,
    REG_CAM_POS_Z   = 3'd2,
    REG_VIEW_AXIS_X = 3'd3,
    REG_VIEW_AXIS_Y = 3'd4,
    REG_VIEW_AXIS_Z = 3'd5
  } vtt_reg_t;

  localparam int CELL_W = 16;
  localparam int AXIS_W = 14;
  localparam int KIND_W = 3;
  localparam int ARC_W  = 4;
  localparam int SLOT_W = 2;
  localparam int COL_W  = 3;
  localparam int TEX_W  = 6;

  localparam logic [SLOT_W-1:0] ARC_LAST = 2'd2;

  localparam logic signed [AXIS_W-1:0] VIEW_AXIS_Z_RST = 14'sd4096;

  localparam int QUEUE_DEPTH = 4;

  // hash constants
  localparam logic [31:0] MIX_XOR = 32'd61;
  localparam logic [31:0] MIX_MUL = 32'h27d4eb2d;

  typedef struct packed {
    logic signed [31:0]       cam_x;
    logic signed [31:0]       cam_y;
    logic signed [31:0]       cam_z;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
  } vtt_cfg_t;

  // one visible cell waiting for arc expansion
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col0;   // colour of cell z
    logic [COL_W-1:0]  col1;   // colour of cell z plus one
  } vtt_entry_t;

  typedef enum logic [1:0] {
    PLANE_X = 2'd0,
    PLANE_Y = 2'd1,
    PLANE_Z = 2'd2
  } vtt_plane_t;

  typedef struct packed {
    vtt_plane_t plane_from;
    logic       off_from;
    vtt_plane_t plane_to;
    logic       off_to;
  } vtt_link_t;

  localparam logic [ARC_W-1:0] TILE_ARCS [8][3] = '{
    '{4'd0, 4'd6, 4'd11}, '{4'd0, 4'd7, 4'd10}, '{4'd1, 4'd7, 4'd8},
    '{4'd1, 4'd4, 4'd11}, '{4'd2, 4'd4, 4'd9},  '{4'd2, 4'd5, 4'd8},
    '{4'd3, 4'd5, 4'd10}, '{4'd3, 4'd6, 4'd9}
  };

  localparam vtt_link_t LINKS [12] = '{
    '{PLANE_Y, 1'b1, PLANE_X, 1'b1}, '{PLANE_X, 1'b0, PLANE_Y, 1'b1},
    '{PLANE_Y, 1'b0, PLANE_X, 1'b0}, '{PLANE_X, 1'b1, PLANE_Y, 1'b0},
    '{PLANE_Z, 1'b0, PLANE_X, 1'b1}, '{PLANE_Z, 1'b0, PLANE_Y, 1'b1},
    '{PLANE_Z, 1'b0, PLANE_X, 1'b0}, '{PLANE_Z, 1'b0, PLANE_Y, 1'b0},
    '{PLANE_Z, 1'b1, PLANE_X, 1'b1}, '{PLANE_Z, 1'b1, PLANE_Y, 1'b1},
    '{PLANE_Z, 1'b1, PLANE_X, 1'b0}, '{PLANE_Z, 1'b1, PLANE_Y, 1'b0}
  };

  // hash round up to the multiply
  function automatic logic [31:0] mix_pre(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 16);
    t = t ^ MIX_XOR;
    t = t + (t << 3);
    t = t ^ (t >> 4);
    return t;
  endfunction

  // hash round after the multiply
  function automatic logic [31:0] mix_post(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

endpackage

### rtl/core/vtt_regs.sv
// apb register file holding camera position and view axis
module vtt_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vtt_pkg::ADDR_W-1:0] paddr,
  input  logic [vtt_pkg::DATA_W-1:0] pwdata,
  output logic [vtt_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output vtt_pkg::vtt_cfg_t         cfg
);
  import vtt_pkg::*;

  logic     wr_en;
  vtt_reg_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = vtt_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_x  <= '0;
      cfg.cam_y  <= '0;
      cfg.cam_z  <= '0;
      cfg.axis_x <= '0;
      cfg.axis_y <= '0;
      cfg.axis_z <= VIEW_AXIS_Z_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CAM_POS_X:   cfg.cam_x  <= pwdata;
        REG_CAM_POS_Y:   cfg.cam_y  <= pwdata;
        REG_CAM_POS_Z:   cfg.cam_z  <= pwdata;
        REG_VIEW_AXIS_X: cfg.axis_x <= pwdata[AXIS_W-1:0];
        REG_VIEW_AXIS_Y: cfg.axis_y <= pwdata[AXIS_W-1:0];
        REG_VIEW_AXIS_Z: cfg.axis_z <= pwdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAM_POS_X:   prdata = cfg.cam_x;
      REG_CAM_POS_Y:   prdata = cfg.cam_y;
      REG_CAM_POS_Z:   prdata = cfg.cam_z;
      REG_VIEW_AXIS_X: prdata = DATA_W'(cfg.axis_x);
      REG_VIEW_AXIS_Y: prdata = DATA_W'(cfg.axis_y);
      REG_VIEW_AXIS_Z: prdata = DATA_W'(cfg.axis_z);
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/core/vtt_front.sv
// front pipeline: view culling, cell hash and colour base per cell
module vtt_front #(
  parameter int FRAC_BITS    = 12,
  parameter int COLOUR_COUNT = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  vtt_pkg::vtt_cfg_t                 cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_x,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_y,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_z,
  input  logic                              q_full,
  output logic                              push,
  output vtt_pkg::vtt_entry_t               push_entry
);
  import vtt_pkg::*;

  // difference vector, products and sum widths
  localparam int DW   = ((CELL_W + FRAC_BITS > 32) ? CELL_W + FRAC_BITS : 32) + 2;
  localparam int PW   = DW + AXIS_W;
  localparam int SW   = PW - FRAC_BITS + 2;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  // z mod COLOUR_COUNT by reciprocal multiply on a biased, non-negative z
  localparam int VW     = CELL_W + 1;
  localparam int RSHIFT = VW + 4;
  localparam int MW     = VW + RSHIFT;
  localparam int ZOFF   = COLOUR_COUNT * ((32768 + COLOUR_COUNT - 1) / COLOUR_COUNT);
  localparam longint RECIP = ((64'd1 << RSHIFT) + COLOUR_COUNT - 1) / COLOUR_COUNT;

  logic adv;

  // stage 1
  logic                     s1_valid;
  logic signed [DW-1:0]     s1_dx, s1_dy, s1_dz;
  logic [31:0]              s1_hash;
  logic signed [CELL_W-1:0] s1_y, s1_z;
  logic [VW-1:0]            s1_v, s1_q;

  // stage 2
  logic                     s2_valid;
  logic signed [PW-1:0]     s2_px, s2_py, s2_pz;
  logic [31:0]              s2_hash;
  logic signed [CELL_W-1:0] s2_z;
  logic [COL_W-1:0]         s2_col0, s2_col1;

  // stage 3
  logic             s3_valid;
  logic             s3_vis;
  logic [31:0]      s3_hash;
  logic [COL_W-1:0] s3_col0, s3_col1;

  logic signed [VW:0]   zs;
  logic [MW-1:0]        zprod;
  logic [VW-1:0]        zrem;
  logic signed [SW-1:0] dot;

  assign adv      = !(s3_valid && s3_vis && q_full);
  assign in_stall = !adv;

  assign zs    = (VW+1)'(cell_z) + (VW+1)'(ZOFF);
  assign zprod = MW'(zs[VW-1:0]) * MW'(RECIP);
  assign zrem  = s1_v - VW'(s1_q * COLOUR_COUNT);

  assign dot = SW'(signed'(s2_px[PW-1:FRAC_BITS]))
             + SW'(signed'(s2_py[PW-1:FRAC_BITS]))
             + SW'(signed'(s2_pz[PW-1:FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // centre minus camera, first hash round, colour quotient
      s1_dx   <= (DW'(cell_x) <<< FRAC_BITS) + DW'(HALF) - DW'(cfg.cam_x);
      s1_dy   <= (DW'(cell_y) <<< FRAC_BITS) + DW'(HALF) - DW'(cfg.cam_y);
      s1_dz   <= (DW'(cell_z) <<< FRAC_BITS) + DW'(HALF) - DW'(cfg.cam_z);
      s1_hash <= mix_pre(32'(cell_x)) * MIX_MUL;
      s1_y    <= cell_y;
      s1_z    <= cell_z;
      s1_v    <= zs[VW-1:0];
      s1_q    <= zprod[MW-1:RSHIFT];

      // axis products, second hash round, colour remainder
      s2_px   <= PW'(cfg.axis_x) * PW'(s1_dx);
      s2_py   <= PW'(cfg.axis_y) * PW'(s1_dy);
      s2_pz   <= PW'(cfg.axis_z) * PW'(s1_dz);
      s2_hash <= mix_pre(mix_post(s1_hash) ^ 32'(s1_y)) * MIX_MUL;
      s2_z    <= s1_z;
      s2_col0 <= zrem[COL_W-1:0];
      s2_col1 <= (zrem[COL_W-1:0] == COL_W'(COLOUR_COUNT - 1)) ? '0
                 : zrem[COL_W-1:0] + COL_W'(1);

      // cull test, third hash round
      s3_vis  <= !(dot > SW'(HALF));
      s3_hash <= mix_pre(mix_post(s2_hash) ^ 32'(s2_z)) * MIX_MUL;
      s3_col0 <= s2_col0;
      s3_col1 <= s2_col1;
    end
  end

  logic [31:0] hash_out;
  assign hash_out = mix_post(s3_hash);

  assign push            = s3_valid && s3_vis && !q_full;
  assign push_entry.kind = hash_out[KIND_W-1:0];
  assign push_entry.col0 = s3_col0;
  assign push_entry.col1 = s3_col1;

endmodule

### rtl/core/vtt_queue.sv
// short register queue between front and back
module vtt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vtt_pkg::vtt_entry_t push_entry,
  input  logic                pop,
  output vtt_pkg::vtt_entry_t head,
  output logic                full,
  output logic                empty
);
  import vtt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vtt_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### rtl/core/vtt_back.sv
// back end: expands each queued cell into three arc requests
module vtt_back #(
  parameter int COLOUR_COUNT = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  vtt_pkg::vtt_entry_t              head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [vtt_pkg::KIND_W-1:0]       tile_kind,
  output logic [vtt_pkg::SLOT_W-1:0]       arc_slot,
  output logic [vtt_pkg::ARC_W-1:0]        arc_kind,
  output logic [vtt_pkg::COL_W-1:0]        colour_from,
  output logic [vtt_pkg::COL_W-1:0]        colour_to,
  output logic [vtt_pkg::TEX_W-1:0]        texture_slot,
  output logic                             last_arc
);
  import vtt_pkg::*;

  logic              load;
  logic [SLOT_W-1:0] arc_cnt;
  logic [ARC_W-1:0]  arc;
  vtt_link_t         link;
  logic [COL_W-1:0]  cf, ct;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !empty && (arc_cnt == ARC_LAST);

  assign arc  = TILE_ARCS[head.kind][arc_cnt];
  assign link = LINKS[arc];
  assign cf   = (link.plane_from == PLANE_Z && link.off_from) ? head.col1 : head.col0;
  assign ct   = (link.plane_to == PLANE_Z && link.off_to) ? head.col1 : head.col0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      arc_cnt   <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        arc_cnt <= (arc_cnt == ARC_LAST) ? '0 : arc_cnt + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      tile_kind    <= head.kind;
      arc_slot     <= arc_cnt;
      arc_kind     <= arc;
      colour_from  <= cf;
      colour_to    <= ct;
      texture_slot <= TEX_W'(32'(cf) * COLOUR_COUNT + 32'(ct));
      last_arc     <= (arc_cnt == ARC_LAST);
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_arc == (arc_slot == ARC_LAST)))
    else $error("last arc flag out of step with slot");
  a_arc_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_arc |=>
      out_valid && arc_slot == $past(arc_slot) + SLOT_W'(1)
      && tile_kind == $past(tile_kind))
    else $error("arc sequence of a cell broken");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> arc_slot != 2'd3)
    else $error("arc slot out of range");

endmodule

### rtl/core/voxel_truchet_tile_generator.sv
// top level of the voxel truchet tile generator
//
// takes one signed cell coordinate per request and, unless the cell centre lies
// more than half a unit in front of the camera along the view axis, returns three
// arc requests for the truchet tile chosen by a hash of the coordinate. the front
// pipeline (three stages: centre minus camera, axis products, sum and cull compare,
// with the three hash rounds and the colour remainder alongside) accepts a cell every
// cycle. visible cells go through a four-entry queue to the back end, which gives one
// arc per cycle from its output register while out_stall is low, three per cell, so
// the result channel sets the sustained rate of visible cells; culled cells pass at
// one per cycle. with the queue empty, a cell's first arc passes the front stages, a
// queue slot and the output register. the input stalls only when a visible cell leaves
// the front while the queue is full. configuration is apb at byte addresses 4*index:
// cam_pos_x/y/z (20.12) then view_axis_x/y/z (14 bit signed); reads sign-extend.
module voxel_truchet_tile_generator #(
  parameter int FRAC_BITS    = 12,
  parameter int COLOUR_COUNT = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [vtt_pkg::ADDR_W-1:0]        paddr,
  input  logic [vtt_pkg::DATA_W-1:0]        pwdata,
  output logic [vtt_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // cell requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_x,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_y,
  input  logic signed [vtt_pkg::CELL_W-1:0] cell_z,
  // arc requests
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vtt_pkg::KIND_W-1:0]        tile_kind,
  output logic [vtt_pkg::SLOT_W-1:0]        arc_slot,
  output logic [vtt_pkg::ARC_W-1:0]         arc_kind,
  output logic [vtt_pkg::COL_W-1:0]         colour_from,
  output logic [vtt_pkg::COL_W-1:0]         colour_to,
  output logic [vtt_pkg::TEX_W-1:0]         texture_slot,
  output logic                              last_arc
);
  import vtt_pkg::*;

  vtt_cfg_t   cfg;
  vtt_entry_t push_entry, head;
  logic       push, pop, q_full, q_empty;

  // camera registers
  vtt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cull, hash and colour base
  vtt_front #(
    .FRAC_BITS    (FRAC_BITS),
    .COLOUR_COUNT (COLOUR_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // visible cells waiting for expansion
  vtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // three arcs per cell, registered output
  vtt_back #(
    .COLOUR_COUNT (COLOUR_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tile_kind    (tile_kind),
    .arc_slot     (arc_slot),
    .arc_kind     (arc_kind),
    .colour_from  (colour_from),
    .colour_to    (colour_to),
    .texture_slot (texture_slot),
    .last_arc     (last_arc)
  );

endmodule

### bench/vtt_arc_monitor.sv
// watches the cell and arc channels, predicts each cell's arcs and counts mismatches
`timescale 1ns / 100ps

module vtt_arc_monitor
  import vtt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  input  logic                     pready,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [CELL_W-1:0] cell_x,
  input  logic signed [CELL_W-1:0] cell_y,
  input  logic signed [CELL_W-1:0] cell_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [KIND_W-1:0]        tile_kind,
  input  logic [SLOT_W-1:0]        arc_slot,
  input  logic [ARC_W-1:0]         arc_kind,
  input  logic [COL_W-1:0]         colour_from,
  input  logic [COL_W-1:0]         colour_to,
  input  logic [TEX_W-1:0]         texture_slot,
  input  logic                     last_arc,
  output int                       fail_count,
  output int                       arcs_due,
  output int                       cells_seen,
  output int                       cells_culled,
  output int                       arcs_checked
);

  localparam int    FRAC    = 12;
  localparam int    COLOURS = 6;
  localparam longint UNIT   = 64'sd1 << FRAC;
  localparam longint HALF   = UNIT / 2;

  // arcs whose start or end endpoint sits on the upper z face, one bit per arc kind
  localparam logic [11:0] LIFT_FROM = 12'b1111_0000_0000;
  localparam logic [11:0] LIFT_TO   = 12'b0000_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ARC_W-1:0]  arc;
    logic [COL_W-1:0]  col_from;
    logic [COL_W-1:0]  col_to;
    logic [TEX_W-1:0]  tex;
    logic              last;
  } arc_t;

  // mirrored register file
  longint cam_x, cam_y, cam_z;
  longint ax, ay, az;

  arc_t arc_q[$];

  task automatic report(input string what);
    $display("ERROR %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [31:0] scramble(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 16);
    t = t ^ MIX_XOR;
    t = t + (t << 3);
    t = t ^ (t >> 4);
    t = t * MIX_MUL;
    t = t ^ (t >> 15);
    return t;
  endfunction

  // three arc kinds per tile, first arc in the top nibble
  function automatic logic [11:0] tile_arcs(input logic [KIND_W-1:0] kind);
    case (kind)
      3'd0: return {4'd0, 4'd6, 4'd11};
      3'd1: return {4'd0, 4'd7, 4'd10};
      3'd2: return {4'd1, 4'd7, 4'd8};
      3'd3: return {4'd1, 4'd4, 4'd11};
      3'd4: return {4'd2, 4'd4, 4'd9};
      3'd5: return {4'd2, 4'd5, 4'd8};
      3'd6: return {4'd3, 4'd5, 4'd10};
      default: return {4'd3, 4'd6, 4'd9};
    endcase
  endfunction

  function automatic int colour_of(input int zz);
    int r;
    r = zz % COLOURS;
    if (r < 0) r += COLOURS;
    return r;
  endfunction

  // cull test, hash and arc expansion of one cell
  function automatic void expand_cell(input logic signed [CELL_W-1:0] x, y, z);
    longint xs, ys, zs, dx, dy, dz, dot;
    logic [31:0] h;
    logic [KIND_W-1:0] kind;
    logic [11:0] arcs;
    logic [ARC_W-1:0] a;
    int zf, zt, cf, ct, i;
    arc_t e;
    xs = x;
    ys = y;
    zs = z;
    dx = xs * UNIT + HALF - cam_x;
    dy = ys * UNIT + HALF - cam_y;
    dz = zs * UNIT + HALF - cam_z;
    dot = ((ax * dx) >>> FRAC) + ((ay * dy) >>> FRAC) + ((az * dz) >>> FRAC);
    cells_seen++;
    if (dot > HALF) begin
      cells_culled++;
      return;
    end
    h = scramble(xs[31:0]);
    h = scramble(h ^ ys[31:0]);
    h = scramble(h ^ zs[31:0]);
    kind = h[KIND_W-1:0];
    arcs = tile_arcs(kind);
    for (i = 0; i < 3; i++) begin
      a = arcs[11-4*i -: 4];
      zf = int'(zs) + (LIFT_FROM[a] ? 1 : 0);
      zt = int'(zs) + (LIFT_TO[a] ? 1 : 0);
      cf = colour_of(zf);
      ct = colour_of(zt);
      e.kind = kind;
      e.slot = SLOT_W'(i);
      e.arc = a;
      e.col_from = COL_W'(cf);
      e.col_to = COL_W'(ct);
      e.tex = TEX_W'(cf * COLOURS + ct);
      e.last = (i == 2);
      arc_q.push_back(e);
    end
  endfunction

  always @(posedge clk) begin : watch
    arc_t got, want;
    if (rst) begin
      cam_x = 0;
      cam_y = 0;
      cam_z = 0;
      ax = 0;
      ay = 0;
      az = UNIT;
      arc_q.delete();
      arcs_due <= 0;
      fail_count = 0;
      cells_seen = 0;
      cells_culled = 0;
      arcs_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (vtt_reg_t'(paddr[ADDR_W-1:2]))
          REG_CAM_POS_X:   cam_x = $signed(pwdata);
          REG_CAM_POS_Y:   cam_y = $signed(pwdata);
          REG_CAM_POS_Z:   cam_z = $signed(pwdata);
          REG_VIEW_AXIS_X: ax = $signed(pwdata[AXIS_W-1:0]);
          REG_VIEW_AXIS_Y: ay = $signed(pwdata[AXIS_W-1:0]);
          REG_VIEW_AXIS_Z: az = $signed(pwdata[AXIS_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expand_cell(cell_x, cell_y, cell_z);
      if (out_valid && !out_stall) begin
        got = {tile_kind, arc_slot, arc_kind, colour_from, colour_to, texture_slot, last_arc};
        arcs_checked++;
        if (arc_q.size() == 0) begin
          report($sformatf("arc kind %0d slot %0d with no cell pending", got.arc, got.slot));
        end else begin
          want = arc_q.pop_front();
          if (got !== want)
            report($sformatf(
              "arc got tile %0d slot %0d arc %0d col %0d/%0d tex %0d last %0d, want %0d %0d %0d %0d/%0d %0d %0d",
              got.kind, got.slot, got.arc, got.col_from, got.col_to, got.tex, got.last,
              want.kind, want.slot, want.arc, want.col_from, want.col_to, want.tex, want.last));
        end
      end
      arcs_due <= arc_q.size();
    end
  end

endmodule

### bench/voxel_truchet_tile_generator_test.sv
// top level testbench of the voxel truchet tile generator: stimulus, stalls and verdict
`timescale 1ns / 100ps

module voxel_truchet_tile_generator_test;
  import vtt_pkg::*;

  // quiet cycles allowed before the run is declared hung
  localparam int WATCHDOG = 1000;
  // cycles a culled cell may still sit in the front pipeline after the last arc
  localparam int DRAIN = 16;
  // register index past the last real register, the block must ignore it
  localparam int SPARE_REG = 7;
  localparam int MAX_CAM = 32'h7fffffff;
  localparam int MIN_CAM = 32'h80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [CELL_W-1:0] cell_x = '0;
  logic signed [CELL_W-1:0] cell_y = '0;
  logic signed [CELL_W-1:0] cell_z = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KIND_W-1:0] tile_kind;
  logic [SLOT_W-1:0] arc_slot;
  logic [ARC_W-1:0]  arc_kind;
  logic [COL_W-1:0]  colour_from;
  logic [COL_W-1:0]  colour_to;
  logic [TEX_W-1:0]  texture_slot;
  logic              last_arc;

  int fail_count, arcs_due, cells_seen, cells_culled, arcs_checked;

  // no idling on either side while set
  logic calm = 1'b0;
  int   quiet = 0;
  int   settings_used = 0;
  // camera position in whole cells, used to aim requests at the cull boundary
  int   cam_cell [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voxel_truchet_tile_generator i_dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .cell_x, .cell_y, .cell_z,
    .out_valid, .out_stall, .tile_kind, .arc_slot, .arc_kind,
    .colour_from, .colour_to, .texture_slot, .last_arc
  );

  vtt_arc_monitor i_arc_monitor (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .cell_x, .cell_y, .cell_z,
    .out_valid, .out_stall, .tile_kind, .arc_slot, .arc_kind,
    .colour_from, .colour_to, .texture_slot, .last_arc,
    .fail_count, .arcs_due, .cells_seen, .cells_culled, .arcs_checked
  );

  // apb write: setup cycle, then access cycle where the register takes the data,
  // then it idles with psel low so back to back writes never drive the bus twice in a step
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // camera position and view axis; axis writes carry junk above bit 13
  task automatic set_view(input int cx, cy, cz, ax, ay, az);
    write_reg(REG_CAM_POS_X, cx);
    write_reg(REG_CAM_POS_Y, cy);
    write_reg(REG_CAM_POS_Z, cz);
    write_reg(REG_VIEW_AXIS_X, {18'($urandom), 14'(ax)});
    write_reg(REG_VIEW_AXIS_Y, {18'($urandom), 14'(ay)});
    write_reg(REG_VIEW_AXIS_Z, {18'($urandom), 14'(az)});
    cam_cell[0] = cx >>> 12;
    cam_cell[1] = cy >>> 12;
    cam_cell[2] = cz >>> 12;
    settings_used++;
  endtask

  // one cell request after a random gap, held until the block takes it
  task automatic send_cell(input int x, y, z);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_x <= 16'(x);
    cell_y <= 16'(y);
    cell_z <= 16'(z);
    do @(posedge clk); while (in_stall);
  endtask

  // wait until every predicted arc has come, then let culled cells flush out
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (arcs_due != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // coordinate shapes: full range, near the camera, near the origin, extremes
  function automatic int pick_coord(input int mode, input int centre);
    case (mode)
      0: return int'($urandom_range(0, 65535));
      1: return centre + int'($urandom_range(0, 16)) - 8;
      2: return int'($urandom_range(0, 16)) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // camera somewhere inside the reachable cell range, random fraction
  function automatic int cam_in_range();
    return (int'($urandom_range(0, 65535)) - 32768) * 4096 + int'($urandom_range(0, 4095));
  endfunction

  function automatic int unit_sign();
    return $urandom_range(0, 1) ? 4096 : -4096;
  endfunction

  // receiver: random hold before each arc, none while calm
  initial begin : receiver
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ends the run if neither channel nor the config port moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int phase, n, count, mode, pick;
    int ax_v [3];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset view looks down +z from the origin: visible exactly when z <= 0
    send_cell(0, 0, 0);           // dot equals one half, still visible
    send_cell(0, 0, 1);           // just past the cull threshold
    send_cell(-32768, -32768, -32768);
    send_cell(32767, 32767, 32767);
    send_cell(32767, -32768, -1);
    send_cell(-1, -1, -7);

    for (phase = 1; phase <= 8; phase++) begin
      settle();
      count = 35;
      case (phase)
        // zero axis: nothing culled
        1: set_view(0, 0, 0, 0, 0, 0);
        // camera far away at both extremes, axes beyond one unit
        2: set_view(MAX_CAM, MAX_CAM, MAX_CAM, 8191, 8191, 8191);
        3: set_view(MIN_CAM, MIN_CAM, MIN_CAM, -8192, -8192, -8192);
        // unit axis along one direction, camera among the cells
        4: begin
          ax_v = '{0, 0, 0};
          pick = $urandom_range(0, 2);
          ax_v[pick] = unit_sign();
          set_view(cam_in_range(), cam_in_range(), cam_in_range(), ax_v[0], ax_v[1], ax_v[2]);
        end
        // fully random register contents
        6: set_view($urandom, $urandom, $urandom, int'($urandom_range(0, 16383)) - 8192,
                    int'($urandom_range(0, 16383)) - 8192, int'($urandom_range(0, 16383)) - 8192);
        // camera far behind along +z: every cell culled, block busy without results
        7: begin
          set_view(0, 0, MIN_CAM, 0, 0, 4096);
          write_reg(SPARE_REG, $urandom);
          count = 12;
        end
        // oblique axis within one unit, camera among the cells
        default:
          set_view(cam_in_range(), cam_in_range(), cam_in_range(),
                   int'($urandom_range(0, 8192)) - 4096, int'($urandom_range(0, 8192)) - 4096,
                   int'($urandom_range(0, 8192)) - 4096);
      endcase

      if (phase == 1) begin
        // colour wrap on negative z and on the 16-bit z top, coordinate extremes
        send_cell(0, 0, 32767);
        send_cell(-32768, 32767, -32768);
        send_cell(-1, -1, -1);
        send_cell(1, 1, -6);
        send_cell(3, -4, -5);
        send_cell(-32768, 0, 5);
        send_cell(32767, 32767, -2);
        send_cell(12, -12, 4);
        send_cell(255, -256, -3);
        send_cell(7, 8, 2);
        send_cell(-9, 10, 3);
        send_cell(-4, 4, -4);
      end

      // a calm stretch at the head of each phase, then random gaps and stalls
      for (n = 0; n < count; n++) begin
        calm = (n < 8);
        mode = $urandom_range(0, 3);
        send_cell(pick_coord(mode, cam_cell[0]), pick_coord(mode, cam_cell[1]),
                  pick_coord(mode, cam_cell[2]));
      end
      calm = 1'b0;
    end
    settle();

    $display("run covered %0d cells (%0d culled) and %0d arcs over %0d register settings",
             cells_seen, cells_culled, arcs_checked, settings_used);
    $display("including cull boundary, oversized view axes, colour wrap and stalls on both sides");
    if (fail_count == 0 && arcs_due == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
